>>> sv/aesg_pkg.sv
// Package for the AES-256-GCM engine: state codes, register indexes,
// S-box table and AES round helpers. No dependencies.
package aesg_pkg;

    localparam int unsigned BLK_W    = 128;
    localparam int unsigned NUM_RND  = 15;
    localparam int unsigned CNT_W    = 36;
    localparam int unsigned ADDR_W   = 6;
    localparam int unsigned DATA_W   = 64;

    typedef enum logic [2:0] {
        REG_KEY0   = 3'd0,
        REG_KEY1   = 3'd1,
        REG_KEY2   = 3'd2,
        REG_KEY3   = 3'd3,
        REG_NONCEH = 3'd4,
        REG_NONCEL = 3'd5,
        REG_DIR    = 3'd6
    } t_reg;

    typedef enum logic [1:0] {
        FN_AAD    = 2'd0,
        FN_TEXT   = 2'd1,
        FN_FINISH = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEXP,
        S_HKEY,
        S_TMASK,
        S_DISP,
        S_CTR,
        S_GHASH,
        S_DONE
    } t_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes, ShiftRows and (unless last) MixColumns, then add round key
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                                input logic [127:0] rk,
                                                input logic last);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   o [16];
        logic [7:0]   all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) begin
            b[i] = s[127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) begin
            t[i] = SBOX[b[(i + 4*(i%4)) % 16]];
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            o[4*c]   = t[4*c]   ^ all ^ xt(t[4*c]   ^ t[4*c+1]);
            o[4*c+1] = t[4*c+1] ^ all ^ xt(t[4*c+1] ^ t[4*c+2]);
            o[4*c+2] = t[4*c+2] ^ all ^ xt(t[4*c+2] ^ t[4*c+3]);
            o[4*c+3] = t[4*c+3] ^ all ^ xt(t[4*c+3] ^ t[4*c]);
        end
        for (int i = 0; i < 16; i++) begin
            res[127-8*i -: 8] = last ? t[i] : o[i];
        end
        return res ^ rk;
    endfunction

endpackage

>>> sv/aes256_gcm_engine.sv
// AES-256-GCM engine top level: key schedule, shared AES round unit,
// 8-bit-per-cycle GHASH multiplier and sequencer. Uses aesg_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | sink      | i_in_valid / o_in_stall| i_func, i_block_high/low, i_valid_bytes
//  out     | source    | o_out_valid/i_out_stall| o_result_high/low, o_is_tag, o_auth_ok
//  cfg     | APB slave | psel/penable/pready    | paddr, pwdata, prdata
//
// AAD word: dispatch, then the GHASH passes. Text word: dispatch, the AES rounds,
// the GHASH passes, then the result hand-off. Finish: dispatch, GHASH, hand-off.
// After a key or nonce write the next word first runs the key schedule and
// two AES passes (hash subkey and tag mask). One word is in flight at a time.
// Reset is synchronous; a held result on a stalled output blocks the next result.
module aes256_gcm_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic [4:0]  i_valid_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    output logic        o_is_tag,
    output logic        o_auth_ok,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [aesg_pkg::ADDR_W-1:0] paddr,
    input  logic [aesg_pkg::DATA_W-1:0] pwdata,
    output logic [aesg_pkg::DATA_W-1:0] prdata,
    output logic        pready
);

    aesg_pkg::t_state r_state, n_state;

    logic [63:0]  r_key [4];
    logic [63:0]  r_nh;
    logic [31:0]  r_nl;
    logic         r_dir;
    logic         r_kready;

    logic [127:0] r_rk [aesg_pkg::NUM_RND];
    logic [31:0]  r_win [8];
    logic [5:0]   r_kidx;

    logic [127:0] r_aes;
    logic [3:0]   r_rnd;

    logic [127:0] r_ga, r_gz, r_gv;
    logic [3:0]   r_gcnt;

    logic [127:0] r_h, r_tmask, r_acc;
    logic [31:0]  r_ctr;
    logic [aesg_pkg::CNT_W-1:0] r_aad, r_txt;

    logic [1:0]   r_func;
    logic [127:0] r_blk, r_mask;
    logic [4:0]   r_vb;
    logic [127:0] r_res;
    logic         r_tag, r_auth;

    logic         r_ovalid;
    logic [127:0] r_obuf;
    logic         r_otag, r_oauth;

    logic         accept, cfg_wr, aes_done, gh_done, out_free;
    logic [4:0]   vb_clamp;
    logic [127:0] in_mask, in_blk;
    logic [127:0] aes_next;
    logic [127:0] gz_next, gv_next, ga_next;
    logic [31:0]  kw_t, kw_new;
    logic [7:0]   rcon;
    logic [127:0] tag_val;

    assign accept   = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign aes_done = (r_rnd == 4'(aesg_pkg::NUM_RND - 1));
    assign gh_done  = (r_gcnt == 4'hf);
    assign out_free = !r_ovalid || !i_out_stall;

    assign vb_clamp = (i_valid_bytes > 5'd16) ? 5'd16 : i_valid_bytes;
    assign in_mask  = ~({128{1'b1}} >> {vb_clamp, 3'b000});
    assign in_blk   = (aesg_pkg::t_func'(i_func) == aesg_pkg::FN_FINISH)
                    ? {i_block_high, i_block_low}
                    : ({i_block_high, i_block_low} & in_mask);

    // round 0 is the plain key add
    assign aes_next = (r_rnd == 4'd0) ? (r_aes ^ r_rk[r_rnd])
                    : aesg_pkg::aes_round(r_aes, r_rk[r_rnd], aes_done);

    always_comb begin
        logic [127:0] z, v, a;
        logic         lsb;
        z = r_gz;
        v = r_gv;
        a = r_ga;
        for (int k = 0; k < 8; k++) begin
            if (a[127]) begin
                z = z ^ v;
            end
            lsb = v[0];
            v = v >> 1;
            if (lsb) begin
                v[127:120] = v[127:120] ^ 8'he1;
            end
            a = a << 1;
        end
        gz_next = z;
        gv_next = v;
        ga_next = a;
    end

    // key schedule word
    assign rcon = 8'h01 << (r_kidx[5:3] - 3'd1);
    always_comb begin
        kw_t = r_win[7];
        case (r_kidx[2:0])
            3'd0: begin
                kw_t = {aesg_pkg::SBOX[r_win[7][23:16]] ^ rcon,
                        aesg_pkg::SBOX[r_win[7][15:8]],
                        aesg_pkg::SBOX[r_win[7][7:0]],
                        aesg_pkg::SBOX[r_win[7][31:24]]};
            end
            3'd4: begin
                kw_t = {aesg_pkg::SBOX[r_win[7][31:24]],
                        aesg_pkg::SBOX[r_win[7][23:16]],
                        aesg_pkg::SBOX[r_win[7][15:8]],
                        aesg_pkg::SBOX[r_win[7][7:0]]};
            end
            default: kw_t = r_win[7];
        endcase
        kw_new = r_win[0] ^ kw_t;
    end

    assign tag_val = gz_next ^ r_tmask;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            aesg_pkg::S_IDLE: begin
                if (accept && aesg_pkg::t_func'(i_func) != aesg_pkg::FN_NONE) begin
                    n_state = r_kready ? aesg_pkg::S_DISP : aesg_pkg::S_KEXP;
                end
            end
            aesg_pkg::S_KEXP:  if (r_kidx == 6'd59) n_state = aesg_pkg::S_HKEY;
            aesg_pkg::S_HKEY:  if (aes_done) n_state = aesg_pkg::S_TMASK;
            aesg_pkg::S_TMASK: if (aes_done) n_state = aesg_pkg::S_DISP;
            aesg_pkg::S_DISP: begin
                case (aesg_pkg::t_func'(r_func))
                    aesg_pkg::FN_AAD:
                        n_state = (r_vb == 5'd0) ? aesg_pkg::S_IDLE : aesg_pkg::S_GHASH;
                    aesg_pkg::FN_TEXT:
                        n_state = (r_vb == 5'd0) ? aesg_pkg::S_DONE : aesg_pkg::S_CTR;
                    default: n_state = aesg_pkg::S_GHASH;
                endcase
            end
            aesg_pkg::S_CTR: if (aes_done) n_state = aesg_pkg::S_GHASH;
            aesg_pkg::S_GHASH: begin
                if (gh_done) begin
                    n_state = (aesg_pkg::t_func'(r_func) == aesg_pkg::FN_AAD)
                            ? aesg_pkg::S_IDLE : aesg_pkg::S_DONE;
                end
            end
            aesg_pkg::S_DONE: if (out_free) n_state = aesg_pkg::S_IDLE;
            default: n_state = aesg_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall    = (r_state != aesg_pkg::S_IDLE);
        o_out_valid   = r_ovalid;
        o_result_high = r_obuf[127:64];
        o_result_low  = r_obuf[63:0];
        o_is_tag      = r_otag;
        o_auth_ok     = r_oauth;
        case (aesg_pkg::t_reg'(paddr[5:3]))
            aesg_pkg::REG_KEY0:   prdata = r_key[0];
            aesg_pkg::REG_KEY1:   prdata = r_key[1];
            aesg_pkg::REG_KEY2:   prdata = r_key[2];
            aesg_pkg::REG_KEY3:   prdata = r_key[3];
            aesg_pkg::REG_NONCEH: prdata = r_nh;
            aesg_pkg::REG_NONCEL: prdata = {32'h0, r_nl};
            aesg_pkg::REG_DIR:    prdata = {63'h0, r_dir};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= aesg_pkg::S_IDLE;
            for (int k = 0; k < 4; k++) r_key[k] <= '0;
            r_nh     <= '0;
            r_nl     <= '0;
            r_dir    <= 1'b0;
            r_kready <= 1'b0;
            r_h      <= '0;
            r_tmask  <= '0;
            r_acc    <= '0;
            r_ctr    <= 32'd2;
            r_aad    <= '0;
            r_txt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                case (aesg_pkg::t_reg'(paddr[5:3]))
                    aesg_pkg::REG_KEY0:   begin r_key[0] <= pwdata; r_kready <= 1'b0; end
                    aesg_pkg::REG_KEY1:   begin r_key[1] <= pwdata; r_kready <= 1'b0; end
                    aesg_pkg::REG_KEY2:   begin r_key[2] <= pwdata; r_kready <= 1'b0; end
                    aesg_pkg::REG_KEY3:   begin r_key[3] <= pwdata; r_kready <= 1'b0; end
                    aesg_pkg::REG_NONCEH: begin r_nh <= pwdata; r_kready <= 1'b0; end
                    aesg_pkg::REG_NONCEL: begin r_nl <= pwdata[31:0]; r_kready <= 1'b0; end
                    aesg_pkg::REG_DIR:    r_dir <= pwdata[0];
                    default: ;
                endcase
            end

            // load a new result word, else drop the one just taken
            if (r_state == aesg_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                aesg_pkg::S_TMASK: begin
                    if (aes_done) r_kready <= 1'b1;
                end
                aesg_pkg::S_HKEY: begin
                    if (aes_done) r_h <= aes_next;
                end
                aesg_pkg::S_GHASH: begin
                    if (gh_done) begin
                        case (aesg_pkg::t_func'(r_func))
                            aesg_pkg::FN_AAD: begin
                                r_acc <= gz_next;
                                r_aad <= r_aad + aesg_pkg::CNT_W'(r_vb);
                            end
                            aesg_pkg::FN_TEXT: begin
                                r_acc <= gz_next;
                                r_ctr <= r_ctr + 32'd1;
                                r_txt <= r_txt + aesg_pkg::CNT_W'(r_vb);
                            end
                            default: begin
                                // finish: drop per-message state
                                r_acc <= '0;
                                r_aad <= '0;
                                r_txt <= '0;
                                r_ctr <= 32'd2;
                            end
                        endcase
                    end
                end
                aesg_pkg::S_DONE: begin
                    if (out_free) begin
                        r_obuf   <= r_res;
                        r_otag   <= r_tag;
                        r_oauth  <= r_auth;
                    end
                end
                default: ;
            endcase
            if (r_state == aesg_pkg::S_TMASK && aes_done) begin
                r_tmask <= aes_next;
            end
        end
    end

    // datapath without reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            aesg_pkg::S_IDLE: begin
                if (accept) begin
                    r_func  <= i_func;
                    r_blk   <= in_blk;
                    r_mask  <= in_mask;
                    r_vb    <= vb_clamp;
                    r_kidx  <= 6'd8;
                    r_rk[0] <= {r_key[0], r_key[1]};
                    r_rk[1] <= {r_key[2], r_key[3]};
                    r_win[0] <= r_key[0][63:32];
                    r_win[1] <= r_key[0][31:0];
                    r_win[2] <= r_key[1][63:32];
                    r_win[3] <= r_key[1][31:0];
                    r_win[4] <= r_key[2][63:32];
                    r_win[5] <= r_key[2][31:0];
                    r_win[6] <= r_key[3][63:32];
                    r_win[7] <= r_key[3][31:0];
                end
            end
            aesg_pkg::S_KEXP: begin
                for (int k = 0; k < 7; k++) r_win[k] <= r_win[k+1];
                r_win[7] <= kw_new;
                r_rk[r_kidx[5:2]][(3 - r_kidx[1:0]) * 32 +: 32] <= kw_new;
                r_kidx <= r_kidx + 6'd1;
                r_aes  <= '0;
                r_rnd  <= '0;
            end
            aesg_pkg::S_HKEY: begin
                if (aes_done) begin
                    r_aes <= {r_nh, r_nl, 32'd1};
                    r_rnd <= '0;
                end else begin
                    r_aes <= aes_next;
                    r_rnd <= r_rnd + 4'd1;
                end
            end
            aesg_pkg::S_TMASK, aesg_pkg::S_CTR: begin
                r_aes <= aes_next;
                r_rnd <= r_rnd + 4'd1;
                if (r_state == aesg_pkg::S_CTR && aes_done) begin
                    r_res  <= (r_blk ^ aes_next) & r_mask;
                    r_tag  <= 1'b0;
                    r_auth <= 1'b0;
                    r_ga   <= r_acc ^ (r_dir ? r_blk : ((r_blk ^ aes_next) & r_mask));
                    r_gz   <= '0;
                    r_gv   <= r_h;
                    r_gcnt <= '0;
                end
            end
            aesg_pkg::S_DISP: begin
                r_aes  <= {r_nh, r_nl, r_ctr};
                r_rnd  <= '0;
                r_gz   <= '0;
                r_gv   <= r_h;
                r_gcnt <= '0;
                r_res  <= '0;
                r_tag  <= 1'b0;
                r_auth <= 1'b0;
                if (aesg_pkg::t_func'(r_func) == aesg_pkg::FN_AAD) begin
                    r_ga <= r_acc ^ r_blk;
                end else begin
                    r_ga <= r_acc ^ {25'h0, r_aad, 3'b000, 25'h0, r_txt, 3'b000};
                end
            end
            aesg_pkg::S_GHASH: begin
                r_ga   <= ga_next;
                r_gz   <= gz_next;
                r_gv   <= gv_next;
                r_gcnt <= r_gcnt + 4'd1;
                if (gh_done && aesg_pkg::t_func'(r_func) == aesg_pkg::FN_FINISH) begin
                    r_res  <= tag_val;
                    r_tag  <= 1'b1;
                    r_auth <= r_dir ? ((tag_val ^ r_blk) == '0) : 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> sv/aesg_checker.sv
// Port-level checker for the AES-256-GCM engine, bound to the top level.
// Uses only the top level's ports.
module aesg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_func,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_is_tag,
    input logic        o_auth_ok
);

    // a held result word stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_auth_tag_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_tag |-> !o_auth_ok)
        else $error("auth_ok set on a text word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
        && aesg_pkg::t_func'(i_func) != aesg_pkg::FN_NONE |=> o_in_stall)
        else $error("input not stalled while a word is in work");

endmodule

bind aes256_gcm_engine aesg_checker u_aesg_checker (.*);
